FILE: src/hfcd_pkg.sv
// Shared constants, command codes and controller/datapath command types
// for the handset frame command decoder. No dependencies.
package hfcd_pkg;

  localparam int LINE_CHARS_DEF   = 12;
  localparam int BUFFER_BYTES_DEF = 32;
  // read address width: covers every payload position a command looks at
  localparam int RD_AW = 5;

  localparam logic [7:0] DELIM = 8'hFF;
  localparam logic [7:0] HOLD  = 8'h0F;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;

  localparam logic [1:0] EV_TEXT   = 2'd0;
  localparam logic [1:0] EV_CLEAR  = 2'd1;
  localparam logic [1:0] EV_STATUS = 2'd2;

  localparam logic [1:0] HL_NONE  = 2'd0;
  localparam logic [1:0] HL_LINE1 = 2'd1;
  localparam logic [1:0] HL_LINE2 = 2'd2;

  // AC payload fields, in payload order after the command letters
  localparam logic [2:0] ACF_GSM   = 3'd0;
  localparam logic [2:0] ACF_PHONE = 3'd1;
  localparam logic [2:0] ACF_SMS   = 3'd2;
  localparam logic [2:0] ACF_GPS   = 3'd3;
  localparam logic [2:0] ACF_BATT  = 3'd4;

  // payload offset of the first argument byte
  localparam logic [RD_AW-1:0] ARG_OFS = RD_AW'(2);

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_DH,
    CMD_SR,
    CMD_RS,
    CMD_AC
  } cmd_code_t;

  typedef struct packed {
    logic             wr_en;
    logic             clr_count;
    logic             rd_en;
    logic [RD_AW-1:0] rd_addr;
    logic             cap_c0;
    logic             clr_hl;
    logic             sr_en;
    logic             ac_en;
    logic [2:0]       ac_field;
    logic             emit;
    logic [1:0]       emit_kind;
    logic [4:0]       emit_idx;
    logic             emit_use_byte;
    logic             emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic      delim;
    logic      full;
    logic      slot_free;
    cmd_code_t cmd;
  } dp_stat_t;

  function automatic cmd_code_t decode_cmd(input logic [7:0] c0, input logic [7:0] c1);
    cmd_code_t r;
    r = CMD_NONE;
    if (c0 == CH_D && c1 == CH_H) r = CMD_DH;
    else if (c0 == CH_S && c1 == CH_R) r = CMD_SR;
    else if (c0 == CH_R && c1 == CH_S) r = CMD_RS;
    else if (c0 == CH_A && c1 == CH_C) r = CMD_AC;
    return r;
  endfunction

endpackage

FILE: src/hfcd_ifs.sv
// Handshake channel interfaces: received byte, display event, config write.
// Standalone; no package dependency.
interface hfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hfcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [4:0] char_index;
  logic [7:0] char_value;
  logic [1:0] highlight_line;
  logic [2:0] gsm_level;
  logic       phone_icon;
  logic       sms_icon;
  logic       gps_icon;
  logic       battery_icon;
  logic       last;
  modport source (output valid, output event_kind, output char_index, output char_value,
                  output highlight_line, output gsm_level, output phone_icon,
                  output sms_icon, output gps_icon, output battery_icon, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input char_index, input char_value,
                  input highlight_line, input gsm_level, input phone_icon,
                  input sms_icon, input gps_icon, input battery_icon, input last,
                  output ready);
endinterface

interface hfcd_cfg_if;
  logic valid;
  logic ready;
  logic rx_enable;
  modport source (output valid, output rx_enable, input ready);
  modport sink   (input valid, input rx_enable, output ready);
endinterface

FILE: src/handset_frame_command_decoder.sv
// Top level of the handset frame command decoder: controller plus datapath.
// Depends on hfcd_pkg, hfcd_ifs (channel interfaces), hfcd_ctrl, hfcd_dp.
//
//  channel | dir | payload                                   | item accepted when
//  --------+-----+-------------------------------------------+-------------------
//  in_ch   | in  | rx_byte[7:0]                              | valid & ready
//  out_ch  | out | event_kind, char_index, char_value,       | valid & ready
//          |     | highlight_line, gsm_level, 4 icons, last  |
//  cfg_ch  | in  | rx_enable                                 | valid & ready
//
// Flow: a byte that only stores or opens a frame is taken in S_IDLE. A closing delimiter
//   runs the sequencer, one store read and at most one result per cycle while out_ch
//   is not stalled; S_C0 and S_C1 fetch the letters, then SR, AC, DH or EMIT follow.
// Reset: rst_n synchronous, active low; rx_enable comes up 1, status clear.
// Stalls: in_ch.ready is high only while the sequencer is idle; a held out_ch.ready
//   freezes result steps, the result register holding its item; cfg_ch.ready is high.
module handset_frame_command_decoder #(
  parameter int LINE_CHARS   = hfcd_pkg::LINE_CHARS_DEF,
  parameter int BUFFER_BYTES = hfcd_pkg::BUFFER_BYTES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  hfcd_in_if.sink     in_ch,
  hfcd_out_if.source  out_ch,
  hfcd_cfg_if.sink    cfg_ch
);

  hfcd_pkg::dp_cmd_t  cmd;    // sequencer -> datapath
  hfcd_pkg::dp_stat_t stat;   // datapath -> sequencer
  logic               in_ready;

  // config writes are for the user to make only while idle (not enforced); the port never stalls
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  hfcd_ctrl #(
    .LINE_CHARS (LINE_CHARS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ready),
    .cfg_we        (cfg_ch.valid),
    .cfg_rx_enable (cfg_ch.rx_enable),
    .stat          (stat),
    .cmd           (cmd)
  );

  // frame store, fill count, status registers and the result register
  hfcd_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_ch.rx_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .event_kind     (out_ch.event_kind),
    .char_index     (out_ch.char_index),
    .char_value     (out_ch.char_value),
    .highlight_line (out_ch.highlight_line),
    .gsm_level      (out_ch.gsm_level),
    .phone_icon     (out_ch.phone_icon),
    .sms_icon       (out_ch.sms_icon),
    .gps_icon       (out_ch.gps_icon),
    .battery_icon   (out_ch.battery_icon),
    .last           (out_ch.last)
  );

endmodule

FILE: src/hfcd_dp.sv
// Datapath: frame store memory with fill count, display status registers
// and the result register. Uses hfcd_pkg.
module hfcd_dp #(
  parameter int BUFFER_BYTES = hfcd_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         rx_byte,
  input  hfcd_pkg::dp_cmd_t  cmd,
  output hfcd_pkg::dp_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         event_kind,
  output logic [4:0]         char_index,
  output logic [7:0]         char_value,
  output logic [1:0]         highlight_line,
  output logic [2:0]         gsm_level,
  output logic               phone_icon,
  output logic               sms_icon,
  output logic               gps_icon,
  output logic               battery_icon,
  output logic               last
);

  localparam int IDXW = $clog2(BUFFER_BYTES);
  localparam int CW   = $clog2(BUFFER_BYTES + 1);
  localparam int CMPW = (CW > hfcd_pkg::RD_AW) ? CW : hfcd_pkg::RD_AW;

  logic [7:0]      mem [BUFFER_BYTES];
  logic [7:0]      mem_q_r;
  logic            rvalid_r;
  logic [CW-1:0]   count_r;
  logic [7:0]      c0_r;
  logic [1:0]      hl_r, hl_nxt;
  logic [2:0]      gsm_r, gsm_nxt;
  logic [3:0]      icon_r, icon_nxt;   // bit0 phone, bit1 sms, bit2 gps, bit3 battery

  logic [1:0]      ev_kind_r;
  logic [4:0]      ev_idx_r;
  logic [7:0]      ev_val_r;
  logic [1:0]      ev_hl_r;
  logic [2:0]      ev_gsm_r;
  logic [3:0]      ev_icon_r;
  logic            ev_last_r;
  logic            out_valid_r;

  logic [7:0]      rd_byte;
  logic            rd_hit;
  logic [IDXW-1:0] rd_idx;
  logic            arg_on, arg_is_one, arg_in_1_5;

  // positions past the fill count read as zero
  assign rd_hit  = CMPW'(cmd.rd_addr) < CMPW'(count_r);
  assign rd_idx  = rd_hit ? IDXW'(cmd.rd_addr) : '0;
  assign rd_byte = rvalid_r ? mem_q_r : 8'h00;

  assign stat.delim     = (rx_byte == hfcd_pkg::DELIM);
  assign stat.full      = (count_r == CW'(BUFFER_BYTES));
  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.cmd       = hfcd_pkg::decode_cmd(c0_r, rd_byte);

  assign arg_is_one = (rd_byte == 8'd1);
  assign arg_in_1_5 = (rd_byte >= 8'd1) && (rd_byte <= 8'd5);
  assign arg_on     = (cmd.ac_field == hfcd_pkg::ACF_BATT) ? arg_in_1_5 : arg_is_one;

  always_comb begin
    hl_nxt   = hl_r;
    gsm_nxt  = gsm_r;
    icon_nxt = icon_r;
    if (cmd.clr_hl) begin
      hl_nxt = hfcd_pkg::HL_NONE;
    end
    if (cmd.sr_en) begin
      hl_nxt = (rd_byte == 8'h00) ? hfcd_pkg::HL_LINE1 : hfcd_pkg::HL_LINE2;
    end
    if (cmd.ac_en && rd_byte != hfcd_pkg::HOLD) begin
      case (cmd.ac_field)
        hfcd_pkg::ACF_GSM:   gsm_nxt   = arg_in_1_5 ? rd_byte[2:0] : 3'd0;
        hfcd_pkg::ACF_PHONE: icon_nxt[0] = arg_on;
        hfcd_pkg::ACF_SMS:   icon_nxt[1] = arg_on;
        hfcd_pkg::ACF_GPS:   icon_nxt[2] = arg_on;
        hfcd_pkg::ACF_BATT:  icon_nxt[3] = arg_on;
        default: ;
      endcase
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[count_r[IDXW-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[rd_idx];
    end
    if (cmd.cap_c0) begin
      c0_r <= rd_byte;
    end
    if (cmd.emit) begin
      ev_kind_r <= cmd.emit_kind;
      ev_idx_r  <= cmd.emit_idx;
      ev_val_r  <= cmd.emit_use_byte ? rd_byte : 8'h00;
      ev_hl_r   <= hl_r;
      ev_gsm_r  <= gsm_r;
      ev_icon_r <= icon_r;
      ev_last_r <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      hl_r        <= hfcd_pkg::HL_NONE;
      gsm_r       <= 3'd0;
      icon_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_count) begin
        count_r <= '0;
      end else if (cmd.wr_en) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.rd_en) begin
        rvalid_r <= rd_hit;
      end
      hl_r   <= hl_nxt;
      gsm_r  <= gsm_nxt;
      icon_r <= icon_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign event_kind     = ev_kind_r;
  assign char_index     = ev_idx_r;
  assign char_value     = ev_val_r;
  assign highlight_line = ev_hl_r;
  assign gsm_level      = ev_gsm_r;
  assign phone_icon     = ev_icon_r[0];
  assign sms_icon       = ev_icon_r[1];
  assign gps_icon       = ev_icon_r[2];
  assign battery_icon   = ev_icon_r[3];
  assign last           = ev_last_r;

endmodule

FILE: src/hfcd_ctrl.sv
// Controller: frame tracking, rx enable register and the decode sequencer
// that drives the datapath. Uses hfcd_pkg.
module hfcd_ctrl #(
  parameter int LINE_CHARS = hfcd_pkg::LINE_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_we,
  input  logic               cfg_rx_enable,
  input  hfcd_pkg::dp_stat_t stat,
  output hfcd_pkg::dp_cmd_t  cmd
);

  localparam int NCHARS = 2 * LINE_CHARS;
  localparam int IW     = (NCHARS > 1) ? $clog2(NCHARS) : 1;
  localparam logic [IW-1:0] LAST_I = IW'(NCHARS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_C0,
    S_C1,
    S_SR,
    S_AC,
    S_DH,
    S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic          rx_en_r;
  logic          in_frame_r, in_frame_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [1:0]    ekind_r, ekind_nxt;
  logic          accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    in_frame_nxt = in_frame_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    ekind_nxt    = ekind_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && rx_en_r) begin
          if (stat.delim) begin
            if (in_frame_r) begin
              // close: fetch first command letter
              in_frame_nxt = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_addr  = '0;
              state_nxt    = S_C0;
            end else begin
              in_frame_nxt  = 1'b1;
              cmd.clr_count = 1'b1;
            end
          end else if (in_frame_r && !stat.full) begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_C0: begin
        cmd.cap_c0  = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = hfcd_pkg::RD_AW'(1);
        state_nxt   = S_C1;
      end
      S_C1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = hfcd_pkg::ARG_OFS;
        case (stat.cmd)
          hfcd_pkg::CMD_DH: begin
            cmd.clr_hl = 1'b1;
            i_nxt      = '0;
            state_nxt  = S_DH;
          end
          hfcd_pkg::CMD_SR: state_nxt = S_SR;
          hfcd_pkg::CMD_RS: begin
            ekind_nxt = hfcd_pkg::EV_CLEAR;
            state_nxt = S_EMIT;
          end
          hfcd_pkg::CMD_AC: begin
            k_nxt     = hfcd_pkg::ACF_GSM;
            state_nxt = S_AC;
          end
          default: begin
            cmd.clr_count = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_SR: begin
        cmd.sr_en = 1'b1;
        ekind_nxt = hfcd_pkg::EV_STATUS;
        state_nxt = S_EMIT;
      end
      S_AC: begin
        cmd.ac_en    = 1'b1;
        cmd.ac_field = k_r;
        cmd.rd_en    = 1'b1;
        cmd.rd_addr  = hfcd_pkg::RD_AW'(k_r) + hfcd_pkg::ARG_OFS + hfcd_pkg::RD_AW'(1);
        if (k_r == hfcd_pkg::ACF_BATT) begin
          ekind_nxt = hfcd_pkg::EV_STATUS;
          state_nxt = S_EMIT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_DH: begin
        if (stat.slot_free) begin
          cmd.emit          = 1'b1;
          cmd.emit_kind     = hfcd_pkg::EV_TEXT;
          cmd.emit_idx      = 5'(i_r);
          cmd.emit_use_byte = 1'b1;
          cmd.emit_last     = (i_r == LAST_I);
          cmd.rd_en         = 1'b1;
          cmd.rd_addr       = hfcd_pkg::RD_AW'(i_r) + hfcd_pkg::ARG_OFS
                              + hfcd_pkg::RD_AW'(1);
          if (i_r == LAST_I) begin
            cmd.clr_count = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = ekind_r;
          cmd.emit_last = 1'b1;
          cmd.clr_count = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rx_en_r    <= 1'b1;
      in_frame_r <= 1'b0;
      i_r        <= '0;
      k_r        <= hfcd_pkg::ACF_GSM;
      ekind_r    <= hfcd_pkg::EV_STATUS;
    end else begin
      state_r    <= state_nxt;
      in_frame_r <= in_frame_nxt;
      i_r        <= i_nxt;
      k_r        <= k_nxt;
      ekind_r    <= ekind_nxt;
      if (cfg_we) begin
        rx_en_r <= cfg_rx_enable;
      end
    end
  end

endmodule

FILE: src/hfcd_chk.sv
// Port-level checker for the handset frame command decoder, bound to the
// top level. Depends on hfcd_pkg and handset_frame_command_decoder.
module hfcd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_kind,
  input logic [4:0] char_index,
  input logic [7:0] char_value,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(char_value))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_kind == hfcd_pkg::EV_TEXT || event_kind == hfcd_pkg::EV_CLEAR
                  || event_kind == hfcd_pkg::EV_STATUS)
    else $error("illegal event kind");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind != hfcd_pkg::EV_TEXT |-> last && char_index == 5'd0
                                                     && char_value == 8'h00)
    else $error("non-text result not a lone final result");

  a_busy_while_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && event_kind == hfcd_pkg::EV_TEXT && !last |-> !in_ready)
    else $error("input taken in the middle of a text burst");

endmodule

bind handset_frame_command_decoder hfcd_chk u_hfcd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .event_kind (out_ch.event_kind),
  .char_index (out_ch.char_index),
  .char_value (out_ch.char_value),
  .last       (out_ch.last)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for handset_frame_command_decoder: framed byte traffic in,
// display events predicted by a scoreboard class and checked in order.
// Depends on hfcd_pkg, the hfcd channel interfaces and the decoder RTL.
module tb_top;

  localparam int LINE_N        = hfcd_pkg::LINE_CHARS_DEF;
  localparam int STORE_N       = hfcd_pkg::BUFFER_BYTES_DEF;
  // longest decode run (DH) plus margin; used before cfg writes and at the end
  localparam int SETTLE_CYCLES = 2 * LINE_N + 16;
  localparam int TARGET_ITEMS  = 310;
  localparam int IDLE_PCT      = 23;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_GUARD   = 100000;

  // icons bit order
  localparam int ICON_PHONE = 0;
  localparam int ICON_SMS   = 1;
  localparam int ICON_GPS   = 2;
  localparam int ICON_BATT  = 3;

  // directed opening traffic
  localparam int DIR_N = 27;
  localparam logic [7:0] DIRECTED [DIR_N] = '{
    8'h00, 8'h7F,                                   // strays outside a frame
    hfcd_pkg::DELIM, hfcd_pkg::DELIM,               // empty frame
    hfcd_pkg::DELIM, hfcd_pkg::CH_R, hfcd_pkg::CH_S, hfcd_pkg::DELIM, // screen clear
    // highlight, arg never received
    hfcd_pkg::DELIM, hfcd_pkg::CH_S, hfcd_pkg::CH_R, hfcd_pkg::DELIM,
    // all icons, max bars
    hfcd_pkg::DELIM, hfcd_pkg::CH_A, hfcd_pkg::CH_C, 8'h05, 8'h01, 8'h01, 8'h01, 8'h05,
    hfcd_pkg::DELIM,
    // text, rest of lines read zero
    hfcd_pkg::DELIM, hfcd_pkg::CH_D, hfcd_pkg::CH_H, 8'h41, 8'hFE, hfcd_pkg::DELIM
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] pos;
    logic [7:0] chr;
    logic [1:0] hl;
    logic [2:0] gsm;
    logic [3:0] icons;
    logic       last;
  } disp_event_t;

  // Predicts the display events of each accepted byte and checks results in order.
  class display_scoreboard;
    bit          rx_en;
    bit          in_frame;
    int unsigned fill;
    logic [7:0]  payload_mem [STORE_N];
    logic [1:0]  hl;
    logic [2:0]  gsm;
    logic [3:0]  icons;
    disp_event_t expected_q [$];
    int unsigned errors;

    function new();
      rx_en    = 1'b1;
      in_frame = 1'b0;
      fill     = 0;
      hl       = hfcd_pkg::HL_NONE;
      gsm      = 3'd0;
      icons    = 4'd0;
      errors   = 0;
      foreach (payload_mem[i]) payload_mem[i] = 8'h00;
    endfunction

    function void set_rx_enable(bit en);
      rx_en = en;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // positions past the store read as zero
    function logic [7:0] payload(int unsigned pos);
      return (pos < STORE_N) ? payload_mem[pos] : 8'h00;
    endfunction

    // status fields always carry the state after decode
    function void push_event(logic [1:0] kind, int unsigned pos, logic [7:0] chr);
      disp_event_t ev;
      ev.kind  = kind;
      ev.pos   = 5'(pos);
      ev.chr   = chr;
      ev.hl    = hl;
      ev.gsm   = gsm;
      ev.icons = icons;
      ev.last  = 1'b0;
      expected_q.push_back(ev);
    endfunction

    function void update_icon(int unsigned bitpos, logic [7:0] code, bit wide);
      if (code == hfcd_pkg::HOLD) return;
      icons[bitpos] = (code == 8'd1) || (wide && code >= 8'd1 && code <= 8'd5);
    endfunction

    function void note_input(logic [7:0] b);
      hfcd_pkg::cmd_code_t cmd;
      int unsigned         n0;
      logic [7:0]          g;
      if (!rx_en) return;
      if (b != hfcd_pkg::DELIM) begin
        // payload beyond the store is dropped
        if (in_frame && fill < STORE_N) begin
          payload_mem[fill] = b;
          fill++;
        end
        return;
      end
      if (in_frame) begin
        n0  = expected_q.size();
        cmd = hfcd_pkg::CMD_NONE;
        if (payload(0) == hfcd_pkg::CH_D && payload(1) == hfcd_pkg::CH_H)
          cmd = hfcd_pkg::CMD_DH;
        else if (payload(0) == hfcd_pkg::CH_S && payload(1) == hfcd_pkg::CH_R)
          cmd = hfcd_pkg::CMD_SR;
        else if (payload(0) == hfcd_pkg::CH_R && payload(1) == hfcd_pkg::CH_S)
          cmd = hfcd_pkg::CMD_RS;
        else if (payload(0) == hfcd_pkg::CH_A && payload(1) == hfcd_pkg::CH_C)
          cmd = hfcd_pkg::CMD_AC;
        case (cmd)
          hfcd_pkg::CMD_DH: begin
            hl = hfcd_pkg::HL_NONE;
            for (int i = 0; i < 2 * LINE_N; i++)
              push_event(hfcd_pkg::EV_TEXT, i, payload(2 + i));
          end
          hfcd_pkg::CMD_SR: begin
            hl = (payload(2) == 8'h00) ? hfcd_pkg::HL_LINE1 : hfcd_pkg::HL_LINE2;
            push_event(hfcd_pkg::EV_STATUS, 0, 8'h00);
          end
          hfcd_pkg::CMD_RS: push_event(hfcd_pkg::EV_CLEAR, 0, 8'h00);
          hfcd_pkg::CMD_AC: begin
            g = payload(2);
            if (g >= 8'd1 && g <= 8'd5) gsm = g[2:0];
            else if (g != hfcd_pkg::HOLD) gsm = 3'd0;
            update_icon(ICON_PHONE, payload(3), 1'b0);
            update_icon(ICON_SMS, payload(4), 1'b0);
            update_icon(ICON_GPS, payload(5), 1'b0);
            update_icon(ICON_BATT, payload(6), 1'b1);
            push_event(hfcd_pkg::EV_STATUS, 0, 8'h00);
          end
          default: ;
        endcase
        if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
      end
      // every delimiter flips framing and empties the store
      in_frame = !in_frame;
      fill     = 0;
      foreach (payload_mem[i]) payload_mem[i] = 8'h00;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task compare(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    task check_result(disp_event_t got);
      disp_event_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected event kind %0d pos %0d char %02h",
                         got.kind, got.pos, got.chr));
        return;
      end
      want = expected_q.pop_front();
      compare("event_kind", 8'(got.kind), 8'(want.kind));
      compare("char_index", 8'(got.pos), 8'(want.pos));
      compare("char_value", got.chr, want.chr);
      compare("highlight_line", 8'(got.hl), 8'(want.hl));
      compare("gsm_level", 8'(got.gsm), 8'(want.gsm));
      compare("phone_icon", 8'(got.icons[ICON_PHONE]), 8'(want.icons[ICON_PHONE]));
      compare("sms_icon", 8'(got.icons[ICON_SMS]), 8'(want.icons[ICON_SMS]));
      compare("gps_icon", 8'(got.icons[ICON_GPS]), 8'(want.icons[ICON_GPS]));
      compare("battery_icon", 8'(got.icons[ICON_BATT]), 8'(want.icons[ICON_BATT]));
      compare("last", 8'(got.last), 8'(want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hfcd_in_if  in_ch ();
  hfcd_out_if out_ch ();
  hfcd_cfg_if cfg_ch ();

  handset_frame_command_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  display_scoreboard sb;
  disp_event_t       seen_ev;
  bit                idle_on;      // random idling on both sides
  int                hold_req;     // receiver hold-off request, in cycles
  int                hold_left;
  int unsigned       items_sent;   // bytes accepted while rx is enabled

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: ready changes at the falling edge. A hold-off request is
  // picked up here and counted down in this process, so the sender keeps
  // pushing bytes into a stalled decoder.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Result monitor: sampled at the rising edge, handshake complete.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_ev.kind  = out_ch.event_kind;
      seen_ev.pos   = out_ch.char_index;
      seen_ev.chr   = out_ch.char_value;
      seen_ev.hl    = out_ch.highlight_line;
      seen_ev.gsm   = out_ch.gsm_level;
      seen_ev.icons = {out_ch.battery_icon, out_ch.gps_icon, out_ch.sms_icon,
                       out_ch.phone_icon};
      seen_ev.last  = out_ch.last;
      sb.check_result(seen_ev);
    end
  end

  // Offer one byte; called at a falling edge, returns at a falling edge.
  // valid stays high into the next byte unless an idle gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid   = 1'b0;
      in_ch.rx_byte = 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (sb.rx_en) items_sent++;
    sb.note_input(b);
    @(negedge clk);
  endtask

  // Sender pause until every predicted event has come out.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Register write only with the decoder quiet. An unknown command yields
  // no events but still runs the sequencer, hence the extra settle cycles.
  task automatic write_rx_enable(input logic en);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid     = 1'b1;
    cfg_ch.rx_enable = en;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_rx_enable(en);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return hfcd_pkg::HOLD;
      2:       return 8'hFE;
      default: return 8'($urandom_range(254));
    endcase
  endfunction

  // AC argument codes: hide, show, bars, keep, out of range
  function automatic logic [7:0] ac_code();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'($urandom_range(2, 5));
      3:       return hfcd_pkg::HOLD;
      4:       return 8'($urandom_range(6, 254));
      default: return 8'($urandom);
    endcase
  endfunction

  // a dangling frame (noise, missing close) is closed first
  task automatic open_frame();
    if (sb.in_frame) send_byte(hfcd_pkg::DELIM);
    send_byte(hfcd_pkg::DELIM);
  endtask

  task automatic send_text_frame(input int unsigned len);
    open_frame();
    send_byte(hfcd_pkg::CH_D);
    send_byte(hfcd_pkg::CH_H);
    repeat (len) send_byte(payload_byte());
    send_byte(hfcd_pkg::DELIM);
  endtask

  // Mostly well-formed frames with random content; some noise, some
  // unknown commands, some frames left unclosed.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 8))
        send_byte(($urandom_range(3) == 0) ? hfcd_pkg::DELIM : 8'($urandom));
      return;
    end
    open_frame();
    if (pick < 38) begin
      send_byte(hfcd_pkg::CH_D);
      send_byte(hfcd_pkg::CH_H);
      // now and then longer, at times past the store, to hit the drop-on-overflow path
      len = ($urandom_range(9) == 0) ? $urandom_range(27, 40) : $urandom_range(0, 26);
      repeat (len) send_byte(payload_byte());
    end else if (pick < 53) begin
      send_byte(hfcd_pkg::CH_S);
      send_byte(hfcd_pkg::CH_R);
      repeat ($urandom_range(0, 2))
        send_byte(($urandom_range(1) == 0) ? 8'h00 : payload_byte());
    end else if (pick < 63) begin
      send_byte(hfcd_pkg::CH_R);
      send_byte(hfcd_pkg::CH_S);
      repeat ($urandom_range(0, 3)) send_byte(payload_byte());
    end else if (pick < 88) begin
      send_byte(hfcd_pkg::CH_A);
      send_byte(hfcd_pkg::CH_C);
      len = ($urandom_range(3) == 0) ? $urandom_range(0, 4) : 5;
      repeat (len) send_byte(ac_code());
    end else begin
      // unknown command, sometimes with one correct letter
      send_byte(($urandom_range(1) == 0) ? hfcd_pkg::CH_D : payload_byte());
      send_byte(payload_byte());
      repeat ($urandom_range(0, 4)) send_byte(payload_byte());
    end
    if ($urandom_range(19) != 0) send_byte(hfcd_pkg::DELIM);
  endtask

  // rx disabled: everything is swallowed, nothing comes out
  task automatic disabled_burst();
    write_rx_enable(1'b0);
    repeat (12) send_byte(($urandom_range(2) == 0) ? hfcd_pkg::DELIM : 8'($urandom));
    write_rx_enable(1'b1);
  endtask

  initial begin
    int unsigned guard;
    int unsigned bursts;
    sb               = new();
    rst_n            = 1'b0;
    idle_on          = 1'b1;
    hold_req         = 0;
    hold_left        = 0;
    items_sent       = 0;
    bursts           = 0;
    in_ch.valid      = 1'b0;
    in_ch.rx_byte    = 8'h00;
    cfg_ch.valid     = 1'b0;
    cfg_ch.rx_enable = 1'b1;
    out_ch.ready     = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    write_rx_enable(1'b1);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

    // backpressure: receiver holds off while full text frames keep coming
    hold_req = LONG_HOLD;
    repeat (3) send_text_frame(2 * LINE_N);
    wait_drained();

    while (items_sent < TARGET_ITEMS) begin
      if ((bursts == 0 && items_sent > 100) || (bursts == 1 && items_sent > 250)) begin
        disabled_burst();
        bursts++;
      end
      // a stretch with no idling on either side
      idle_on = !(items_sent >= 150 && items_sent < 230);
      send_random_frame();
      if ($urandom_range(9) == 0) wait_drained();
    end
    idle_on = 1'b1;

    in_ch.valid = 1'b0;
    guard       = 0;
    while (sb.pending() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d expected events never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: handset_frame_command_decoder.f
src/hfcd_pkg.sv
src/hfcd_ifs.sv
src/hfcd_dp.sv
src/hfcd_ctrl.sv
src/handset_frame_command_decoder.sv
src/hfcd_chk.sv
dv/tb_top.sv
